// ===== rtl/core/sbc_pkg.sv =====
package sbc_pkg;

   localparam int unsigned ARGB_W     = 32;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned SPAN_W     = 9;
   localparam int unsigned COORD_W    = 12;
   localparam int unsigned ATLAS_W    = 13;
   localparam int unsigned SCREEN_IDX_W = 17;
   localparam int unsigned SOURCE_IDX_W = 24;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 16;

   localparam int unsigned ALPHA_SHIFT = 24;
   localparam logic [7:0]  ALPHA_CLEAR = 8'h00;

   localparam logic [SPAN_W-1:0]  SPAN_MAX       = 9'd256;
   localparam logic [SPAN_W-1:0]  RECT_W_RESET   = 9'd16;
   localparam logic [SPAN_W-1:0]  RECT_H_RESET   = 9'd16;
   localparam logic [ATLAS_W-1:0] ATLAS_W_RESET  = 13'd256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEST_X      = 3'd0,
      REG_DEST_Y      = 3'd1,
      REG_SRC_LEFT    = 3'd2,
      REG_SRC_TOP     = 3'd3,
      REG_RECT_WIDTH  = 3'd4,
      REG_RECT_HEIGHT = 3'd5,
      REG_ATLAS_WIDTH = 3'd6,
      REG_MIRROR      = 3'd7
   } csr_index_type;

   // dest_x and dest_y hold two's complement values
   typedef struct packed {
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic [COORD_W-1:0] src_left;
      logic [COORD_W-1:0] src_top;
      logic [SPAN_W-1:0]  rect_width;
      logic [SPAN_W-1:0]  rect_height;
      logic [ATLAS_W-1:0] atlas_width;
      logic               mirror;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [ARGB_W-1:0]  pixel;
      logic [COUNT_W-1:0] col;
      logic [COUNT_W-1:0] row;
      logic               last;
   } pipe_type;

   // width/height of 0 counts as 1, anything above 256 as 256
   function automatic logic [SPAN_W-1:0] span(input logic [SPAN_W-1:0] v);
      logic [SPAN_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = 9'd1;
      end else if (v > SPAN_MAX) begin
         r = SPAN_MAX;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/sbc_if.sv =====
interface sbc_req_if;
   logic                           valid;
   logic                           ready;
   logic [sbc_pkg::ARGB_W-1:0]     argb;

   modport source (output valid, output argb, input ready);
   modport sink   (input valid, input argb, output ready);
endinterface

interface sbc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               write_enable;
   logic [sbc_pkg::SCREEN_IDX_W-1:0]   screen_index;
   logic [sbc_pkg::ARGB_W-1:0]         color;
   logic [sbc_pkg::SOURCE_IDX_W-1:0]   source_index;
   logic                               last;

   modport source (output valid, output write_enable, output screen_index, output color,
                   output source_index, output last, input ready);
   modport sink   (input valid, input write_enable, input screen_index, input color,
                   input source_index, input last, output ready);
endinterface

interface sbc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sbc_pkg::CSR_INDEX_W-1:0]   index;
   logic [sbc_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sbc_csr.sv =====
module sbc_csr (
   input  logic              clock,
   input  logic              reset,
   sbc_csr_if.sink           csr_chan,
   output sbc_pkg::cfg_type  cfg
);

   sbc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            sbc_pkg::REG_DEST_X:      cfg_in.dest_x      = csr_chan.data[11:0];
            sbc_pkg::REG_DEST_Y:      cfg_in.dest_y      = csr_chan.data[11:0];
            sbc_pkg::REG_SRC_LEFT:    cfg_in.src_left    = csr_chan.data[11:0];
            sbc_pkg::REG_SRC_TOP:     cfg_in.src_top     = csr_chan.data[11:0];
            sbc_pkg::REG_RECT_WIDTH:  cfg_in.rect_width  = csr_chan.data[8:0];
            sbc_pkg::REG_RECT_HEIGHT: cfg_in.rect_height = csr_chan.data[8:0];
            sbc_pkg::REG_ATLAS_WIDTH: cfg_in.atlas_width = csr_chan.data[12:0];
            sbc_pkg::REG_MIRROR:      cfg_in.mirror      = csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff             <= '0;
         cfg_ff.rect_width  <= sbc_pkg::RECT_W_RESET;
         cfg_ff.rect_height <= sbc_pkg::RECT_H_RESET;
         cfg_ff.atlas_width <= sbc_pkg::ATLAS_W_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/sbc_seq.sv =====
module sbc_seq (
   input  logic               clock,
   input  logic               reset,
   input  sbc_pkg::cfg_type   cfg,
   sbc_req_if.sink            req_chan,
   input  logic               down_ready,
   output sbc_pkg::pipe_type  stage
);

   logic [sbc_pkg::COUNT_W-1:0] col_ff, col_in, row_ff, row_in;
   sbc_pkg::pipe_type           stage_ff, stage_in;
   logic [sbc_pkg::SPAN_W-1:0]  w, h;
   logic                        row_end, rect_end, take;

   assign req_chan.ready = !stage_ff.valid || down_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      w        = sbc_pkg::span(cfg.rect_width);
      h        = sbc_pkg::span(cfg.rect_height);
      // a count at or past the edge of a shrunk rectangle still ends the row
      row_end  = ({1'b0, col_ff} + 9'd1) >= w;
      rect_end = row_end && (({1'b0, row_ff} + 9'd1) >= h);

      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (row_end) begin
            col_in = '0;
            row_in = rect_end ? '0 : row_ff + 8'd1;
         end else begin
            col_in = col_ff + 8'd1;
         end
      end

      stage_in = stage_ff;
      if (take) begin
         stage_in.valid = 1'b1;
         stage_in.pixel = req_chan.argb;
         stage_in.col   = col_ff;
         stage_in.row   = row_ff;
         stage_in.last  = rect_end;
      end else if (down_ready) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.pixel <= stage_in.pixel;
      stage_ff.col   <= stage_in.col;
      stage_ff.row   <= stage_in.row;
      stage_ff.last  <= stage_in.last;
   end

   assign stage = stage_ff;

endmodule

// ===== rtl/core/sbc_calc.sv =====
module sbc_calc #(
   parameter int unsigned SCREEN_WIDTH  = 320,
   parameter int unsigned SCREEN_HEIGHT = 240
) (
   input  logic               clock,
   input  logic               reset,
   input  sbc_pkg::cfg_type   cfg,
   input  sbc_pkg::pipe_type  stage,
   output logic               up_ready,
   sbc_rsp_if.source          rsp_chan
);

   localparam int unsigned POS_W = sbc_pkg::COORD_W + 1;

   logic                                 valid_ff, valid_in;
   logic                                 we_ff, we_in;
   logic [sbc_pkg::SCREEN_IDX_W-1:0]     scr_ff, scr_in;
   logic [sbc_pkg::ARGB_W-1:0]           color_ff;
   logic [sbc_pkg::SOURCE_IDX_W-1:0]     src_ff, src_in;
   logic                                 last_ff;

   logic [POS_W-1:0]                     sx, sy;
   logic                                 on_screen, opaque;
   logic [23:0]                          scr_full;
   logic [sbc_pkg::SPAN_W-1:0]           w;
   logic [sbc_pkg::SOURCE_IDX_W-1:0]     lookup, row_base;
   logic [sbc_pkg::ATLAS_W-1:0]          atlas_row;
   logic                                 load;

   assign up_ready = !valid_ff || rsp_chan.ready;
   assign load     = stage.valid && up_ready;

   always_comb begin
      // sign-extended origin plus count, 13 bits cover every reachable position
      sx = {cfg.dest_x[sbc_pkg::COORD_W-1], cfg.dest_x} + {5'd0, stage.col};
      sy = {cfg.dest_y[sbc_pkg::COORD_W-1], cfg.dest_y} + {5'd0, stage.row};
      on_screen = !sx[POS_W-1] && ({1'b0, sx[POS_W-2:0]} < POS_W'(SCREEN_WIDTH)) &&
                  !sy[POS_W-1] && ({1'b0, sy[POS_W-2:0]} < POS_W'(SCREEN_HEIGHT));
      opaque    = stage.pixel[sbc_pkg::ALPHA_SHIFT +: 8] != sbc_pkg::ALPHA_CLEAR;

      scr_full = 24'(sy[POS_W-2:0]) * 24'(SCREEN_WIDTH) + 24'(sx[POS_W-2:0]);
      scr_in   = on_screen ? scr_full[sbc_pkg::SCREEN_IDX_W-1:0] : '0;
      we_in    = on_screen && opaque;

      w        = sbc_pkg::span(cfg.rect_width);
      // mirrored lookup wraps modulo 2^24 past a shrunk rectangle
      lookup   = cfg.mirror ? (24'(w) - 24'd1 - 24'(stage.col)) : 24'(stage.col);
      atlas_row = {1'b0, cfg.src_top} + 13'(stage.row);
      row_base = 24'(atlas_row) * 24'(cfg.atlas_width);
      src_in   = row_base + 24'(cfg.src_left) + lookup;

      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         we_ff    <= we_in;
         scr_ff   <= scr_in;
         color_ff <= stage.pixel;
         src_ff   <= src_in;
         last_ff  <= stage.last;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.write_enable = we_ff;
   assign rsp_chan.screen_index = scr_ff;
   assign rsp_chan.color        = color_ff;
   assign rsp_chan.source_index = src_ff;
   assign rsp_chan.last         = last_ff;

endmodule

// ===== rtl/core/sprite_blit_clip_flip_alpha_top.sv =====
// channel    interface    dir  payload
// req_chan   sbc_req_if   in   argb
// rsp_chan   sbc_rsp_if   out  write_enable, screen_index, color, source_index, last
// csr_chan   sbc_csr_if   in   index, data (always ready)
//
// One pixel per clock while rsp is ready; the input register and the result register
// sit either side of the address multiplier.
// Synchronous active-high reset clears the counters, both valid flags and the
// registers to their defaults.
// A stalled result holds both stages; req ready follows rsp ready through them.
module sprite_blit_clip_flip_alpha_top #(
   parameter int unsigned SCREEN_WIDTH  = 320,
   parameter int unsigned SCREEN_HEIGHT = 240
) (
   input  logic        clock,
   input  logic        reset,
   sbc_req_if.sink     req_chan,
   sbc_rsp_if.source   rsp_chan,
   sbc_csr_if.sink     csr_chan
);

   sbc_pkg::cfg_type  cfg;
   sbc_pkg::pipe_type stage;
   logic              calc_ready;

   sbc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   sbc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .down_ready (calc_ready),
      .stage      (stage)
   );

   sbc_calc #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_calc (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .stage    (stage),
      .up_ready (calc_ready),
      .rsp_chan (rsp_chan)
   );

   // both stages full and output stalled: no new transaction may enter
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input accepted while pipeline full");

   a_alpha_gate: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.write_enable) |->
      (rsp_chan.color[sbc_pkg::ALPHA_SHIFT +: 8] != sbc_pkg::ALPHA_CLEAR))
      else $error("write enabled for transparent pixel");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_chan.valid && !stage.valid))
      else $error("pipeline not empty after reset");

endmodule
